// ===== design/smc_pkg.sv =====
// Shared types, constants and a helper function for the shifted majority consensus block.
package smc_pkg;

   // Window and counter dimensions.
   localparam int READ_LEN   = 108;
   localparam int MAX_SHIFT  = 40;
   localparam int COUNT_BITS = 16;

   // Field widths.
   localparam int BASE_BITS  = 2;
   localparam int SHIFT_BITS = 6;
   localparam int POS_BITS   = 7;
   localparam int ADDR_BITS  = $clog2(READ_LEN);
   localparam int NUM_BASES  = 4;

   // Four base counters for one position, indexed by base code.
   typedef logic [NUM_BASES-1:0][COUNT_BITS-1:0] count_vec_type;

   // Control of the count memory ports.
   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
   } mem_ctl_type;

   // Base code with the highest count; ties go to the lowest code.
   function automatic logic [BASE_BITS-1:0] majority_base(count_vec_type counts);
      logic [BASE_BITS-1:0]  best;
      logic [COUNT_BITS-1:0] best_cnt;
      best     = '0;
      best_cnt = counts[0];
      for (int j = 1; j < NUM_BASES; j++) begin
         if (counts[j] > best_cnt) begin
            best     = BASE_BITS'(j);
            best_cnt = counts[j];
         end
      end
      return best;
   endfunction

endpackage

// ===== design/shifted_majority_consensus_top.sv =====
// A result passes through stage one (memory read), then the result register (count update).
// Throughput: one base per cycle unless the result side stalls, set by the single read port
// and single write port of the count memory; the next base's read overlaps this base's write.
// Reset (synchronous, active high) clears the position counter, read mode and shift, the
// pipeline valids and the per-entry valid bits, so all counts read as zero at once.
module shifted_majority_consensus_top
   import smc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BASE_BITS-1:0]  req_base,
   input  logic                  req_reset_mode,
   input  logic [SHIFT_BITS-1:0] req_shift,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BASE_BITS-1:0]  rsp_consensus_base,
   output logic [BASE_BITS-1:0]  rsp_complement_base,
   output logic [POS_BITS-1:0]   rsp_position,
   output logic [POS_BITS-1:0]   rsp_mirror_position,
   output logic                  rsp_read_done
);

   // Read state.
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [SHIFT_BITS-1:0] shift_ff, shift_in;
   logic                  mode_ff, mode_in;

   // Stage one: item waiting on its count read.
   logic                  s1_valid_ff, s1_valid_in;
   logic [POS_BITS-1:0]   s1_pos_ff;
   logic [BASE_BITS-1:0]  s1_base_ff;
   logic                  s1_fresh_ff;
   logic                  s1_done_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BASE_BITS-1:0]  rsp_cons_ff;
   logic [POS_BITS-1:0]   rsp_pos_ff;
   logic                  rsp_done_ff;

   logic                  req_xfer;
   logic                  s1_fire;
   logic [SHIFT_BITS-1:0] shift_sat;
   logic [SHIFT_BITS-1:0] cur_shift;
   logic                  cur_mode;
   logic [POS_BITS:0]     src;
   logic                  fresh;
   logic                  done;
   mem_ctl_type           mem_ctl;
   count_vec_type         rd_counts;
   count_vec_type         new_counts;

   // Handshake: stage one moves on when the result register is free or being emptied.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_xfer  = req_valid && !req_stall;

   // Mode and shift come from the first base of a read.
   always_comb begin
      if ({1'b0, req_shift} >= (SHIFT_BITS + 1)'(MAX_SHIFT)) begin
         shift_sat = SHIFT_BITS'(MAX_SHIFT - 1);
      end else begin
         shift_sat = req_shift;
      end
      if (pos_ff == '0) begin
         cur_shift = shift_sat;
         cur_mode  = req_reset_mode;
      end else begin
         cur_shift = shift_ff;
         cur_mode  = mode_ff;
      end
      src   = {1'b0, pos_ff} + (POS_BITS + 1)'(cur_shift);
      fresh = cur_mode || (src >= (POS_BITS + 1)'(READ_LEN));
      done  = req_last || (pos_ff == POS_BITS'(READ_LEN - 1));
   end

   // Next read state on an input transfer.
   always_comb begin
      pos_in   = pos_ff;
      shift_in = shift_ff;
      mode_in  = mode_ff;
      if (req_xfer) begin
         shift_in = cur_shift;
         mode_in  = cur_mode;
         pos_in   = done ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
         mode_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         mode_ff  <= mode_in;
      end
   end

   // Memory ports: read the source position now, write the updated position from stage one.
   always_comb begin
      mem_ctl.rd_en   = req_xfer;
      mem_ctl.rd_addr = fresh ? pos_ff[ADDR_BITS-1:0] : src[ADDR_BITS-1:0];
      mem_ctl.wr_en   = s1_fire;
      mem_ctl.wr_addr = s1_pos_ff[ADDR_BITS-1:0];
   end

   smc_count_mem u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (new_counts),
      .rd_data (rd_counts)
   );

   // Stage one register.
   assign s1_valid_in = req_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pos_ff   <= pos_ff;
         s1_base_ff  <= req_base;
         s1_fresh_ff <= fresh;
         s1_done_ff  <= done;
      end
   end

   // Count update: zero on restart or out-of-window source, then add the new base, saturating.
   always_comb begin
      new_counts = s1_fresh_ff ? '0 : rd_counts;
      if (new_counts[s1_base_ff] != '1) begin
         new_counts[s1_base_ff] = new_counts[s1_base_ff] + 1'b1;
      end
   end

   // Result register.
   always_comb begin
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_cons_ff <= majority_base(new_counts);
         rsp_pos_ff  <= s1_pos_ff;
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_consensus_base  = rsp_cons_ff;
   assign rsp_complement_base = ~rsp_cons_ff;
   assign rsp_position        = rsp_pos_ff;
   assign rsp_mirror_position = POS_BITS'(READ_LEN - 1) - rsp_pos_ff;
   assign rsp_read_done       = rsp_done_ff;

endmodule

// ===== design/smc_count_mem.sv =====
// Per-position base count memory with valid bits and write-to-read forwarding.
module smc_count_mem
   import smc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mem_ctl_type   ctl,
   input  count_vec_type wr_data,
   output count_vec_type rd_data
);

   count_vec_type        mem_ff [READ_LEN];
   logic [READ_LEN-1:0]  valid_ff;
   count_vec_type        rd_data_ff;
   logic                 fwd;

   // A write landing on the address being read in the same cycle is passed straight over.
   assign fwd = ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);

   // An entry never written since reset reads as all counts zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   // Count storage write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         if (fwd) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[ctl.rd_addr]) begin
            rd_data_ff <= mem_ff[ctl.rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/smc_checker.sv =====
// Port-level checker for the shifted majority consensus block, with its bind.
module smc_checker
   import smc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [BASE_BITS-1:0]  rsp_consensus_base,
   input logic [BASE_BITS-1:0]  rsp_complement_base,
   input logic [POS_BITS-1:0]   rsp_position,
   input logic [POS_BITS-1:0]   rsp_mirror_position,
   input logic                  rsp_read_done
);

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_consensus_base)
         && $stable(rsp_position) && $stable(rsp_read_done))
      else $error("stalled result changed");

   // The complement is the bitwise inverse of the consensus code.
   a_complement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_complement_base == ~rsp_consensus_base)
      else $error("complement mismatch");

   // The mirrored slot matches the position.
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mirror_position == POS_BITS'(READ_LEN - 1) - rsp_position)
      else $error("mirror position mismatch");

   // The last position of the window always ends the read.
   a_end_of_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position == POS_BITS'(READ_LEN - 1) |-> rsp_read_done)
      else $error("read not ended at last position");

   // With nothing stalled on the result side, a new base is never refused.
   a_no_refuse: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_stall |-> !req_stall)
      else $error("input stalled without back pressure");

endmodule

bind shifted_majority_consensus_top smc_checker u_smc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_consensus_base  (rsp_consensus_base),
   .rsp_complement_base (rsp_complement_base),
   .rsp_position        (rsp_position),
   .rsp_mirror_position (rsp_mirror_position),
   .rsp_read_done       (rsp_read_done)
);

// ===== sim/shifted_majority_consensus_top_test.sv =====
// Self-checking testbench for the shifted majority consensus block.
`timescale 1ns / 100ps

module shifted_majority_consensus_top_test;
   import smc_pkg::*;

   typedef enum logic [BASE_BITS-1:0] {BASE_A, BASE_C, BASE_G, BASE_T} base_code_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_style_type;

   // One consensus result as the block reports it.
   typedef struct packed {
      logic [BASE_BITS-1:0] cons;
      logic [BASE_BITS-1:0] comp;
      logic [POS_BITS-1:0]  pos;
      logic [POS_BITS-1:0]  mirror;
      logic                 done;
   } consensus_type;

   // One row of the directed stimulus; want is used only where typed is set.
   typedef struct {
      base_code_type         base;
      logic                  restart;
      logic [SHIFT_BITS-1:0] shift;
      logic                  last;
      logic                  typed;
      consensus_type         want;
   } stim_row_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam int GENOME_LEN      = 4096;
   localparam int RANDOM_ITEMS    = 820;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_stall;
   logic [BASE_BITS-1:0]  req_base;
   logic                  req_reset_mode;
   logic [SHIFT_BITS-1:0] req_shift;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BASE_BITS-1:0]  rsp_consensus_base;
   logic [BASE_BITS-1:0]  rsp_complement_base;
   logic [POS_BITS-1:0]   rsp_position;
   logic [POS_BITS-1:0]   rsp_mirror_position;
   logic                  rsp_read_done;

   // Predictor state: per-position base tallies and the current read's settings.
   logic [COUNT_BITS-1:0] tally [READ_LEN][NUM_BASES];
   int                    read_pos;
   int                    read_shift_now;
   logic                  read_restart;

   consensus_type         consensus_pending [$];
   consensus_type         oldest;
   consensus_type         observed;
   int                    mismatches = 0;
   int                    results_seen = 0;
   int                    sent_count;
   int                    idle_cycles;
   int                    holdoff_req = 0;
   int                    holdoff_len = 0;
   int                    burst_left;
   logic                  gap_enable;
   logic [BASE_BITS-1:0]  genome [GENOME_LEN];
   int                    genome_ofs;

   // Short directed reads: shift extremes, every base, ties, early and single-base reads.
   stim_row_type directed_rows [15] = '{
      '{BASE_A, 1'b1, 6'd0,  1'b0, 1'b1, '{2'd0, 2'd3, 7'd0, 7'd107, 1'b0}},
      '{BASE_T, 1'b1, 6'd5,  1'b1, 1'b1, '{2'd3, 2'd0, 7'd1, 7'd106, 1'b1}},
      '{BASE_C, 1'b0, 6'd63, 1'b0, 1'b0, '0},
      '{BASE_G, 1'b1, 6'd0,  1'b1, 1'b0, '0},
      '{BASE_G, 1'b0, 6'd0,  1'b1, 1'b0, '0},
      '{BASE_T, 1'b0, 6'd0,  1'b1, 1'b0, '0},
      '{BASE_A, 1'b0, 6'd40, 1'b1, 1'b0, '0},
      '{BASE_T, 1'b1, 6'd0,  1'b1, 1'b1, '{2'd3, 2'd0, 7'd0, 7'd107, 1'b1}},
      '{BASE_C, 1'b0, 6'd1,  1'b0, 1'b0, '0},
      '{BASE_G, 1'b0, 6'd0,  1'b0, 1'b0, '0},
      '{BASE_A, 1'b0, 6'd0,  1'b1, 1'b0, '0},
      '{BASE_A, 1'b1, 6'd39, 1'b1, 1'b1, '{2'd0, 2'd3, 7'd0, 7'd107, 1'b1}},
      '{BASE_C, 1'b0, 6'd0,  1'b1, 1'b0, '0},
      '{BASE_T, 1'b1, 6'd0,  1'b0, 1'b1, '{2'd3, 2'd0, 7'd0, 7'd107, 1'b0}},
      '{BASE_G, 1'b0, 6'd0,  1'b1, 1'b1, '{2'd2, 2'd1, 7'd1, 7'd106, 1'b1}}
   };

   shifted_majority_consensus_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_base            (req_base),
      .req_reset_mode      (req_reset_mode),
      .req_shift           (req_shift),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_consensus_base  (rsp_consensus_base),
      .rsp_complement_base (rsp_complement_base),
      .rsp_position        (rsp_position),
      .rsp_mirror_position (rsp_mirror_position),
      .rsp_read_done       (rsp_read_done)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the tallies by one base and returns the consensus it yields.
   function automatic consensus_type predict_consensus(input logic [BASE_BITS-1:0] b,
                                                       input logic restart,
                                                       input logic [SHIFT_BITS-1:0] sh,
                                                       input logic last);
      consensus_type r;
      int            pos;
      int            src;
      int            top;
      pos = (read_pos >= READ_LEN) ? 0 : read_pos;
      // The first base of a read latches its mode and shift.
      if (pos == 0) begin
         read_shift_now = (int'(sh) >= MAX_SHIFT) ? MAX_SHIFT - 1 : int'(sh);
         read_restart   = restart;
      end
      if (read_restart || pos + read_shift_now >= READ_LEN) begin
         for (int j = 0; j < NUM_BASES; j++) tally[pos][j] = '0;
         tally[pos][b] = COUNT_BITS'(1);
         r.cons = b;
      end else begin
         src = pos + read_shift_now;
         for (int j = 0; j < NUM_BASES; j++) tally[pos][j] = tally[src][j];
         if (tally[pos][b] != COUNT_MAX) tally[pos][b] = tally[pos][b] + 1'b1;
         // Strictly greater wins, so ties stay with the lowest code.
         r.cons = '0;
         top = 0;
         for (int j = 0; j < NUM_BASES; j++) begin
            if (int'(tally[pos][j]) > top) begin
               top    = int'(tally[pos][j]);
               r.cons = BASE_BITS'(j);
            end
         end
      end
      r.comp   = ~r.cons;
      r.pos    = POS_BITS'(pos);
      r.mirror = POS_BITS'(READ_LEN - 1 - pos);
      r.done   = last || (pos == READ_LEN - 1);
      read_pos = r.done ? 0 : pos + 1;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               field, results_seen, got, want);
      mismatches++;
   endtask

   // Offers one base in bursts with random gaps and waits for its transfer.
   task automatic send_base(input base_code_type b, input logic restart,
                            input logic [SHIFT_BITS-1:0] sh, input logic last,
                            input logic typed, input consensus_type typed_want);
      int            gap;
      consensus_type predicted;
      @(negedge clock);
      if (gap_enable && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid      <= 1'b1;
      req_base       <= b;
      req_reset_mode <= restart;
      req_shift      <= sh;
      req_last       <= last;
      do @(posedge clock); while (req_stall);
      predicted = predict_consensus(b, restart, sh, last);
      consensus_pending.insert(consensus_pending.size(), typed ? typed_want : predicted);
      sent_count++;
   endtask

   // Sends one read sampled from the genome, with a given rate of sequencing errors.
   task automatic send_read(input int len, input logic restart,
                            input logic [SHIFT_BITS-1:0] sh, input logic end_mark,
                            input int error_pct);
      logic [BASE_BITS-1:0] b;
      genome_ofs = (genome_ofs + ((int'(sh) >= MAX_SHIFT) ? MAX_SHIFT - 1 : int'(sh)))
                   % GENOME_LEN;
      for (int p = 0; p < len; p++) begin
         if ($urandom_range(0, 99) < error_pct) b = BASE_BITS'($urandom);
         else b = genome[(genome_ofs + p) % GENOME_LEN];
         // Mode and shift on later bases are ignored, so they carry junk there.
         if (p == 0) send_base(base_code_type'(b), restart, sh,
                               (len == 1) ? end_mark : 1'b0, 1'b0, '0);
         else send_base(base_code_type'(b), 1'($urandom), SHIFT_BITS'($urandom),
                        (p == len - 1) ? end_mark : 1'b0, 1'b0, '0);
      end
   endtask

   // Receiver: changes its stall style every so often, and honors long hold-offs.
   initial begin
      stall_style_type stall_style;
      int              pattern_left;
      int              holdoff_left;
      int              holdoff_seen;
      logic [15:0]     stall_mask;
      stall_style  = STALL_NONE;
      pattern_left = 0;
      holdoff_left = 0;
      holdoff_seen = 0;
      stall_mask   = '0;
      rsp_stall   <= 1'b0;
      forever begin
         @(negedge clock);
         // A new hold-off request starts a countdown kept here.
         if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            holdoff_left = holdoff_len;
         end
         if (holdoff_left > 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else begin
            if (pattern_left == 0) begin
               stall_style  = stall_style_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(20, 200);
               stall_mask   = 16'($urandom);
            end
            pattern_left--;
            case (stall_style)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 2) == 0);
               end
               STALL_PATTERN: begin
                  rsp_stall <= stall_mask[pattern_left % 16];
               end
               default: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
            endcase
         end
      end
   end

   // Compares each result transfer with the oldest pending expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = '{rsp_consensus_base, rsp_complement_base, rsp_position,
                      rsp_mirror_position, rsp_read_done};
         if (consensus_pending.size() == 0) begin
            report_mismatch("unexpected result", int'(observed), 0);
         end else begin
            oldest = consensus_pending.pop_front();
            if (observed.cons != oldest.cons)
               report_mismatch("consensus_base", int'(observed.cons), int'(oldest.cons));
            if (observed.comp != oldest.comp)
               report_mismatch("complement_base", int'(observed.comp), int'(oldest.comp));
            if (observed.pos != oldest.pos)
               report_mismatch("position", int'(observed.pos), int'(oldest.pos));
            if (observed.mirror != oldest.mirror)
               report_mismatch("mirror_position", int'(observed.mirror),
                               int'(oldest.mirror));
            if (observed.done != oldest.done)
               report_mismatch("read_done", int'(observed.done), int'(oldest.done));
         end
         results_seen++;
      end
   end

   // Watchdog: ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("shifted_majority_consensus_top_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, directed reads, then random reads.
   initial begin
      int                    random_goal;
      int                    read_kind;
      int                    noise_len;
      logic [SHIFT_BITS-1:0] shift_pick;
      req_valid      <= 1'b0;
      req_base       <= '0;
      req_reset_mode <= 1'b0;
      req_shift      <= '0;
      req_last       <= 1'b0;
      sent_count     = 0;
      burst_left     = 0;
      gap_enable     = 1'b1;
      genome_ofs     = 0;
      read_pos       = 0;
      read_shift_now = 0;
      read_restart   = 1'b0;
      for (int p = 0; p < READ_LEN; p++)
         for (int j = 0; j < NUM_BASES; j++) tally[p][j] = '0;
      for (int g = 0; g < GENOME_LEN; g++) genome[g] = BASE_BITS'($urandom);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_base(directed_rows[i].base, directed_rows[i].restart, directed_rows[i].shift,
                   directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);

      // Hold the receiver off while a full read streams in, so the block backs up.
      random_goal = sent_count + RANDOM_ITEMS;
      gap_enable  = 1'b0;
      holdoff_len = 300;
      holdoff_req++;
      send_read(READ_LEN, 1'b1, 6'd0, 1'b1, 0);

      while (sent_count < random_goal) begin
         read_kind  = $urandom_range(0, 9);
         gap_enable = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: shift_pick = SHIFT_BITS'($urandom_range(0, 4));
            6, 7:             shift_pick = SHIFT_BITS'($urandom_range(5, MAX_SHIFT - 1));
            8:                shift_pick = SHIFT_BITS'($urandom_range(MAX_SHIFT, 63));
            default:          shift_pick = '0;
         endcase
         if (read_kind == 4) begin
            holdoff_len = $urandom_range(50, 300);
            holdoff_req++;
         end
         if (read_kind < 5) begin
            // Full reads; some omit the final marker and rely on the window end.
            send_read(READ_LEN, ($urandom_range(0, 7) == 0), shift_pick,
                      1'($urandom_range(0, 1)), 10);
         end else if (read_kind < 8) begin
            send_read($urandom_range(1, READ_LEN - 1), ($urandom_range(0, 7) == 0),
                      shift_pick, 1'b1, 10);
         end else begin
            // Noise: every field random, with stray end markers.
            noise_len = $urandom_range(1, 30);
            repeat (noise_len)
               send_base(base_code_type'($urandom_range(0, 3)), 1'($urandom),
                         SHIFT_BITS'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (consensus_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("shifted_majority_consensus_top_test passed");
      end else begin
         $display("shifted_majority_consensus_top_test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/smc_pkg.sv
design/smc_count_mem.sv
design/shifted_majority_consensus_top.sv
design/smc_checker.sv
sim/shifted_majority_consensus_top_test.sv
